/* hdl/css_pkg.sv */
// Package for the cyclic subgroup stepper: word width, codes and shared types.
// Used by every module of the block and by the testbench.
`default_nettype none

package css_pkg;

    localparam int WORD_BITS = 16;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE    = 1'd1;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_MUL = 1'b1;

    localparam logic [WORD_BITS-1:0] SUM_IDENTITY            = '0;
    localparam logic [WORD_BITS-1:0] MULTIPLICATIVE_IDENTITY = WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] MIN_MODULUS             = WORD_BITS'(2);

    typedef struct packed {
        logic                 start_req;
        logic [WORD_BITS-1:0] generator;
    } t_in_item;

    typedef struct packed {
        logic [WORD_BITS-1:0] element;
        logic                 last;
        logic                 generator_ok;
    } t_out_item;

    typedef struct packed {
        logic                 start;
        logic                 add;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic [WORD_BITS-1:0] n;
    } t_mm_req;

    typedef struct packed {
        logic                 done;
        logic [WORD_BITS-1:0] result;
    } t_mm_rsp;

    typedef struct packed {
        logic                 start;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
    } t_gcd_req;

    typedef struct packed {
        logic done;
        logic coprime;
    } t_gcd_rsp;

endpackage

`default_nettype wire

/* hdl/css_chan_if.sv */
// Valid/ready channel carrying one item of a payload type.
// Depends on nothing; the payload type is given at instantiation.
`default_nettype none

interface css_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/css_modmul.sv */
// Bit-serial modular multiplier, MSB first, with a modular add that is done in the cycle after its request.
// Depends on css_pkg for the word width and the request and response types.
`default_nettype none

module css_modmul (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire css_pkg::t_mm_req i_req,
    output css_pkg::t_mm_rsp      o_rsp
);
    localparam int W        = css_pkg::WORD_BITS;
    localparam int CNT_BITS = $clog2(W + 1);

    logic [W-1:0]        r_acc;
    logic [W-1:0]        r_sa;
    logic [W-1:0]        r_b;
    logic [W-1:0]        r_n;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [W:0] w_dbl;
    logic [W:0] w_dbl_red;
    logic [W:0] w_sum;
    logic [W:0] w_sum_red;
    logic [W:0] w_add;
    logic [W:0] w_add_red;

    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, r_n}) ? w_dbl - {1'b0, r_n} : w_dbl;
        w_sum     = w_dbl_red + (r_sa[W-1] ? {1'b0, r_b} : '0);
        w_sum_red = (w_sum >= {1'b0, r_n}) ? w_sum - {1'b0, r_n} : w_sum;
        w_add     = {1'b0, i_req.a} + {1'b0, i_req.b};
        w_add_red = (w_add >= {1'b0, i_req.n}) ? w_add - {1'b0, i_req.n} : w_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_b <= i_req.b;
                r_n <= i_req.n;
                if (i_req.add) begin
                    r_acc  <= w_add_red[W-1:0];
                    r_done <= 1'b1;
                end else begin
                    r_acc  <= '0;
                    r_sa   <= i_req.a;
                    r_cnt  <= CNT_BITS'(W);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_acc <= w_sum_red[W-1:0];
                r_sa  <= {r_sa[W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == CNT_BITS'(1) && !i_req.start |=> r_done && !r_busy)
        else $error("multiplier did not finish after its last bit");
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && !$past(i_req.add) |-> r_acc < r_n)
        else $error("multiplier result not reduced below the modulus");
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("multiplier busy with an empty bit count");

endmodule

`default_nettype wire

/* hdl/css_gcd.sv */
// Coprimality test by the binary GCD method, one subtract or shift per cycle.
// Depends on css_pkg for the word width and the request and response types.
`default_nettype none

module css_gcd (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire css_pkg::t_gcd_req i_req,
    output css_pkg::t_gcd_rsp      o_rsp
);
    localparam int W = css_pkg::WORD_BITS;

    logic [W-1:0] r_a;
    logic [W-1:0] r_b;
    logic         r_busy;
    logic         r_done;
    logic         r_coprime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_coprime <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                priority if (r_a == '0 || r_b == '0) begin
                    r_coprime <= ((r_a | r_b) == W'(1));
                    r_done    <= 1'b1;
                    r_busy    <= 1'b0;
                end else if (!r_a[0] && !r_b[0]) begin
                    r_coprime <= 1'b0;
                    r_done    <= 1'b1;
                    r_busy    <= 1'b0;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a >= r_b) begin
                    r_a <= (r_a - r_b) >> 1;
                end else begin
                    r_b <= (r_b - r_a) >> 1;
                end
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.coprime = r_coprime;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("GCD finished without having run");
    a_odd_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_req.start) && $past(r_busy) && r_a != '0 && r_b != '0
            |-> r_a[0] || r_b[0] || $past(!r_a[0] && !r_b[0]))
        else $error("GCD lost the odd operand");
    a_coprime_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_a == W'(1) && r_b == '0 && !i_req.start |=> r_done && r_coprime)
        else $error("GCD of one not reported as coprime");

endmodule

`default_nettype wire

/* hdl/cyclic_subgroup_stepper_core.sv */
// Cyclic subgroup stepper: one element of the subgroup of Z_n per item.
// Depends on css_pkg, css_chan_if, css_modmul and css_gcd.
// The block takes one item at a time; input ready is high only while it waits
// for an item, and a result waits in the output register without holding up
// the next item. In multiplicative mode an advance item runs from acceptance
// through S_STEP_GO, two passes through the bit-serial modular multiplier in
// S_STEP and S_NEXT, and S_OUT back to S_IDLE. In additive mode both steps are
// modular additions done by the same unit. After the modulus has been changed,
// a held generator that is not below it is first reduced by one multiplier
// pass, and in additive mode so is such a current element. A start item is
// reduced by one multiplier pass; in multiplicative mode the binary GCD unit
// then checks that it is coprime to the modulus.
`default_nettype none

module cyclic_subgroup_stepper_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    css_chan_if.sink                                i_item,
    css_chan_if.source                              o_result,
    input  wire logic                               i_cfg_we,
    input  wire logic [css_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [css_pkg::WORD_BITS-1:0]      i_cfg_data
);
    localparam int W = css_pkg::WORD_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GEN_RED,
        S_GCD,
        S_FIN,
        S_G_RED,
        S_STEP_GO,
        S_CUR_RED,
        S_STEP,
        S_NEXT,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [W-1:0]       r_modulus;
    logic               r_mode_cfg;
    logic [W-1:0]       r_n;
    logic               r_mode;
    logic [W-1:0]       r_cur;
    logic [W-1:0]       r_held_g;
    logic [W-1:0]       r_gm;
    logic               r_running;
    css_pkg::t_out_item r_res;
    css_pkg::t_out_item r_out;
    logic               r_out_valid;
    css_pkg::t_mm_req   r_mm_req;
    css_pkg::t_gcd_req  r_gcd_req;

    css_pkg::t_mm_rsp   w_mm_rsp;
    css_pkg::t_gcd_rsp  w_gcd_rsp;
    css_pkg::t_in_item  w_in;
    logic [W-1:0]       w_n;
    logic [W-1:0]       w_id_cfg;
    logic [W-1:0]       w_id;
    logic               w_in_acc;
    logic               w_out_free;

    assign w_in       = i_item.payload;
    assign w_in_acc   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_n        = (r_modulus < css_pkg::MIN_MODULUS) ? css_pkg::MIN_MODULUS : r_modulus;
    assign w_id_cfg   = (r_mode_cfg == css_pkg::MODE_MUL) ?
                        css_pkg::MULTIPLICATIVE_IDENTITY : css_pkg::SUM_IDENTITY;
    assign w_id       = (r_mode == css_pkg::MODE_MUL) ?
                        css_pkg::MULTIPLICATIVE_IDENTITY : css_pkg::SUM_IDENTITY;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= css_pkg::MIN_MODULUS;
            r_mode_cfg <= css_pkg::MODE_ADD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                css_pkg::CFG_MODULUS: r_modulus  <= i_cfg_data;
                css_pkg::CFG_MODE:    r_mode_cfg <= i_cfg_data[0];
                default:              r_mode_cfg <= r_mode_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_running       <= 1'b0;
            r_cur           <= '0;
            r_held_g        <= '0;
            r_out_valid     <= 1'b0;
            r_mm_req.start  <= 1'b0;
            r_gcd_req.start <= 1'b0;
        end else begin
            r_mm_req.start  <= 1'b0;
            r_gcd_req.start <= 1'b0;
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_n    <= w_n;
                        r_mode <= r_mode_cfg;
                        if (w_in.start_req) begin
                            r_mm_req <= '{start: 1'b1, add: 1'b0, a: w_in.generator,
                                          b: css_pkg::MULTIPLICATIVE_IDENTITY, n: w_n};
                            r_state  <= S_GEN_RED;
                        end else if (r_running) begin
                            if (r_held_g >= w_n) begin
                                r_mm_req <= '{start: 1'b1, add: 1'b0, a: r_held_g,
                                              b: css_pkg::MULTIPLICATIVE_IDENTITY, n: w_n};
                                r_state  <= S_G_RED;
                            end else begin
                                r_gm    <= r_held_g;
                                r_state <= S_STEP_GO;
                            end
                        end else begin
                            r_res   <= '{element: w_id_cfg, last: 1'b1, generator_ok: 1'b0};
                            r_state <= S_OUT;
                        end
                    end
                end
                S_GEN_RED: begin
                    if (w_mm_rsp.done) begin
                        r_gm <= w_mm_rsp.result;
                        if (r_mode == css_pkg::MODE_MUL) begin
                            r_gcd_req <= '{start: 1'b1, a: r_n, b: w_mm_rsp.result};
                            r_state   <= S_GCD;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_GCD: begin
                    if (w_gcd_rsp.done) begin
                        if (w_gcd_rsp.coprime) begin
                            r_state <= S_FIN;
                        end else begin
                            r_res     <= '{element: w_id, last: 1'b1, generator_ok: 1'b0};
                            r_running <= 1'b0;
                            r_state   <= S_OUT;
                        end
                    end
                end
                S_FIN: begin
                    r_held_g <= r_gm;
                    r_cur    <= w_id;
                    r_res    <= '{element: w_id, last: (r_gm == w_id), generator_ok: 1'b1};
                    r_running <= (r_gm != w_id);
                    r_state  <= S_OUT;
                end
                S_G_RED: begin
                    if (w_mm_rsp.done) begin
                        r_gm    <= w_mm_rsp.result;
                        r_state <= S_STEP_GO;
                    end
                end
                S_STEP_GO: begin
                    if (r_mode == css_pkg::MODE_MUL) begin
                        r_mm_req <= '{start: 1'b1, add: 1'b0, a: r_cur, b: r_gm, n: r_n};
                        r_state  <= S_STEP;
                    end else if (r_cur >= r_n) begin
                        r_mm_req <= '{start: 1'b1, add: 1'b0, a: r_cur,
                                      b: css_pkg::MULTIPLICATIVE_IDENTITY, n: r_n};
                        r_state  <= S_CUR_RED;
                    end else begin
                        r_mm_req <= '{start: 1'b1, add: 1'b1, a: r_cur, b: r_gm, n: r_n};
                        r_state  <= S_STEP;
                    end
                end
                S_CUR_RED: begin
                    if (w_mm_rsp.done) begin
                        r_mm_req <= '{start: 1'b1, add: 1'b1, a: w_mm_rsp.result,
                                      b: r_gm, n: r_n};
                        r_state  <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (w_mm_rsp.done) begin
                        r_cur    <= w_mm_rsp.result;
                        r_mm_req <= '{start: 1'b1, add: (r_mode == css_pkg::MODE_ADD),
                                      a: w_mm_rsp.result, b: r_gm, n: r_n};
                        r_state  <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (w_mm_rsp.done) begin
                        r_res <= '{element: r_cur, last: (w_mm_rsp.result == w_id),
                                   generator_ok: 1'b1};
                        if (w_mm_rsp.result == w_id) begin
                            r_running <= 1'b0;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    css_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mm_req),
        .o_rsp   (w_mm_rsp)
    );

    css_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_gcd_req),
        .o_rsp   (w_gcd_rsp)
    );

    assign i_item.ready     = (r_state == S_IDLE);
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_item.ready)
        else $error("item taken while the previous one is still in work");
    a_mm_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_rsp.done |-> r_state == S_GEN_RED || r_state == S_G_RED ||
                          r_state == S_CUR_RED || r_state == S_STEP || r_state == S_NEXT)
        else $error("multiplier result arrived with nobody waiting");
    a_gcd_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gcd_rsp.done |-> r_state == S_GCD)
        else $error("GCD result arrived with nobody waiting");
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && r_out_valid && !o_result.ready |=> r_state == S_OUT)
        else $error("result left for a full output register");

endmodule

`default_nettype wire

/* dv/tb_cyclic_subgroup_stepper_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for cyclic_subgroup_stepper_core: it drives start and advance items,
// writes the modulus and mode registers between phases and checks every result against its own
// model of the subgroup walk. Depends on css_pkg, css_chan_if and the block's RTL.

module tb_cyclic_subgroup_stepper_core;

    localparam int CYCLE_LIMIT  = 800_000;
    localparam int TARGET_ITEMS = 750;
    localparam int DRAIN_CYCLES = 80;
    localparam int LONG_WALK    = 48;

    typedef logic [css_pkg::WORD_BITS-1:0] t_word;

    class subgroup_tracker;
        t_word              modulus_reg;
        logic               mode_reg;
        t_word              cur_element;
        t_word              held_gen;
        bit                 running;
        css_pkg::t_out_item expected_results[$];
        int                 failures;
        int                 items;
        int                 starts;
        int                 non_units;
        int                 idle_advances;
        int                 full_walks;
        int                 checked;

        function new();
            modulus_reg   = css_pkg::MIN_MODULUS;
            mode_reg      = css_pkg::MODE_ADD;
            cur_element   = '0;
            held_gen      = '0;
            running       = 1'b0;
            failures      = 0;
            items         = 0;
            starts        = 0;
            non_units     = 0;
            idle_advances = 0;
            full_walks    = 0;
            checked       = 0;
        endfunction

        static function t_word eff_modulus(t_word m);
            return (m < css_pkg::MIN_MODULUS) ? css_pkg::MIN_MODULUS : m;
        endfunction

        static function t_word identity_of(logic mode);
            return (mode == css_pkg::MODE_MUL) ? css_pkg::MULTIPLICATIVE_IDENTITY
                                               : css_pkg::SUM_IDENTITY;
        endfunction

        static function t_word group_step(t_word a, t_word g, t_word n, logic mode);
            logic [2*css_pkg::WORD_BITS-1:0] x;
            logic [2*css_pkg::WORD_BITS-1:0] y;
            x = a % n;
            y = g % n;
            if (mode == css_pkg::MODE_MUL) begin
                return t_word'((x * y) % n);
            end
            return t_word'((x + y) % n);
        endfunction

        static function bit coprime(t_word a, t_word b);
            t_word r;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return a == 1;
        endfunction

        // Number of steps for the walk to return to the identity; 0 for a non-unit generator,
        // and anything above LONG_WALK means the walk is long.
        static function int cycle_length(t_word g, t_word n, logic mode);
            t_word gr;
            t_word e;
            t_word id;
            int    k;
            gr = g % n;
            id = identity_of(mode);
            if (mode == css_pkg::MODE_MUL && !coprime(n, gr)) begin
                return 0;
            end
            e = id;
            k = 0;
            do begin
                e = group_step(e, gr, n, mode);
                k++;
            end while (e != id && k <= LONG_WALK);
            return k;
        endfunction

        function void write_reg(logic [css_pkg::CFG_IDX_BITS-1:0] idx, t_word data);
            if (idx == css_pkg::CFG_MODULUS) begin
                modulus_reg = data;
            end else if (idx == css_pkg::CFG_MODE) begin
                mode_reg = data[0];
            end
        endfunction

        function void note_item(css_pkg::t_in_item it);
            t_word              n;
            t_word              id;
            t_word              g;
            css_pkg::t_out_item r;
            n  = eff_modulus(modulus_reg);
            id = identity_of(mode_reg);
            items++;
            if (it.start_req) begin
                starts++;
                g = it.generator % n;
                r.element = id;
                if (mode_reg == css_pkg::MODE_MUL && !coprime(n, g)) begin
                    non_units++;
                    r.last         = 1'b1;
                    r.generator_ok = 1'b0;
                    running        = 1'b0;
                end else begin
                    held_gen       = g;
                    cur_element    = id;
                    r.generator_ok = 1'b1;
                    r.last         = (group_step(id, g, n, mode_reg) == id);
                    running        = !r.last;
                    if (r.last) begin
                        full_walks++;
                    end
                end
            end else if (running) begin
                cur_element    = group_step(cur_element, held_gen, n, mode_reg);
                r.element      = cur_element;
                r.generator_ok = 1'b1;
                r.last         = (group_step(cur_element, held_gen, n, mode_reg) == id);
                if (r.last) begin
                    running = 1'b0;
                    full_walks++;
                end
            end else begin
                idle_advances++;
                r.element      = id;
                r.last         = 1'b1;
                r.generator_ok = 1'b0;
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(css_pkg::t_out_item got);
            css_pkg::t_out_item exp;
            bit                 bad;
            checked++;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("Result %0d arrived with nothing expected: element %h last %b ok %b",
                             checked, got.element, got.last, got.generator_ok);
                end
                return;
            end
            exp = expected_results.pop_front();
            bad = 1'b0;
            if (got.element !== exp.element) bad = 1'b1;
            if (got.last !== exp.last) bad = 1'b1;
            if (got.generator_ok !== exp.generator_ok) bad = 1'b1;
            if (bad) begin
                failures++;
                if (failures <= 10) begin
                    $display("Mismatch on result %0d: element %h/%h last %b/%b ok %b/%b (exp/got)",
                             checked, exp.element, got.element, exp.last, got.last,
                             exp.generator_ok, got.generator_ok);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void close_out();
            if (expected_results.size() != 0) begin
                failures += expected_results.size();
                $display("%0d expected results never arrived.", expected_results.size());
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [css_pkg::CFG_IDX_BITS-1:0] i_cfg_idx;
    t_word i_cfg_data;

    css_chan_if #(.t_payload(css_pkg::t_in_item))  in_ch ();
    css_chan_if #(.t_payload(css_pkg::t_out_item)) out_ch ();

    cyclic_subgroup_stepper_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch),
        .o_result   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    subgroup_tracker   tracker = new();
    css_pkg::t_in_item item_batch[$];
    int                settings_used;
    int                cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Cycle limit reached with %0d results outstanding.", tracker.pending());
        $display("** cyclic_subgroup_stepper_core: FAILED **");
        $finish;
    end

    // The receiver follows a rotating stall pattern, redrawn now and then, with some free stretches.
    initial begin
        logic [15:0] stall_pat;
        bit          free_run;
        int          stretch;
        out_ch.ready = 1'b0;
        stall_pat    = 16'h1;
        free_run     = 1'b0;
        stretch      = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stretch == 0) begin
                stretch   = $urandom_range(16, 96);
                stall_pat = 16'($urandom) | 16'h1;
                free_run  = ($urandom_range(0, 3) == 0);
            end
            stretch--;
            out_ch.ready <= free_run | stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            tracker.check_result(out_ch.payload);
        end
    end

    task automatic set_regs(input t_word modulus, input logic mode);
        t_word junk;
        t_word mode_word;
        junk      = t_word'($urandom);
        mode_word = {junk[css_pkg::WORD_BITS-1:1], mode};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= css_pkg::CFG_MODULUS;
        i_cfg_data <= modulus;
        @(posedge i_clk);
        tracker.write_reg(css_pkg::CFG_MODULUS, modulus);
        @(negedge i_clk);
        i_cfg_idx  <= css_pkg::CFG_MODE;
        i_cfg_data <= mode_word;
        @(posedge i_clk);
        tracker.write_reg(css_pkg::CFG_MODE, mode_word);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic void push_start(t_word g);
        css_pkg::t_in_item it;
        it.start_req = 1'b1;
        it.generator = g;
        item_batch.push_back(it);
    endfunction

    function automatic void push_advances(int count);
        css_pkg::t_in_item it;
        for (int k = 0; k < count; k++) begin
            it.start_req = 1'b0;
            it.generator = t_word'($urandom);
            item_batch.push_back(it);
        end
    endfunction

    // Sends the batch in bursts of random length with random gaps; entered and left at a falling edge.
    task automatic drive_batch();
        int burst_left;
        int gap;
        burst_left = 0;
        foreach (item_batch[k]) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            in_ch.valid   <= 1'b1;
            in_ch.payload <= item_batch[k];
            do @(posedge i_clk); while (in_ch.ready !== 1'b1);
            tracker.note_item(item_batch[k]);
            burst_left--;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b0;
        item_batch.delete();
    endtask

    task automatic run_phase();
        drive_batch();
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    function automatic t_word pick_modulus();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return t_word'($urandom_range(2, 40));
        if (r < 80) return t_word'($urandom_range(41, 400));
        if (r < 90) return t_word'($urandom_range(401, 65535));
        if (r < 95) return t_word'($urandom_range(0, 1));
        return t_word'($urandom_range(65534, 65535));
    endfunction

    task automatic random_phase();
        t_word modulus;
        t_word n;
        t_word g;
        logic  mode;
        int    walk;
        int    r;
        modulus = pick_modulus();
        mode    = ($urandom_range(0, 1) == 1) ? css_pkg::MODE_MUL : css_pkg::MODE_ADD;
        n       = subgroup_tracker::eff_modulus(modulus);
        set_regs(modulus, mode);
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 7) == 0) begin
                push_advances($urandom_range(1, 2));
            end
            g = t_word'($urandom);
            if (mode == css_pkg::MODE_MUL && $urandom_range(0, 1) == 1) begin
                for (int t = 0; t < 8 && !subgroup_tracker::coprime(n, g % n); t++) begin
                    g = t_word'($urandom);
                end
            end
            walk = subgroup_tracker::cycle_length(g, n, mode);
            r    = $urandom_range(0, 99);
            push_start(g);
            if (walk == 0) begin
                push_advances($urandom_range(0, 1));
            end else if (walk > LONG_WALK) begin
                push_advances($urandom_range(1, 24));
            end else if (r < 70) begin
                push_advances(walk - 1);
            end else if (r < 85) begin
                push_advances($urandom_range(0, walk - 1));
            end else begin
                push_advances(walk - 1 + $urandom_range(1, 2));
            end
        end
        run_phase();
    endtask

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = css_pkg::CFG_MODULUS;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        settings_used = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: advance while idle, a walk of two, then idle again.
        push_advances(1);
        push_start(16'hFFFF);
        push_advances(2);
        run_phase();

        // A modulus of zero saturates to two; a unit that wraps at once, then a non-unit.
        set_regs(16'h0000, css_pkg::MODE_MUL);
        push_start(16'd3);
        push_start(16'd0);
        push_advances(1);
        run_phase();

        set_regs(16'h0001, css_pkg::MODE_ADD);
        push_start(16'd1);
        push_advances(2);
        run_phase();

        set_regs(16'hFFFF, css_pkg::MODE_MUL);
        push_start(16'd2);
        push_advances(3);
        push_start(16'd3);
        push_start(16'hFFFF);
        push_start(16'h8000);
        run_phase();

        // The registers change while a walk is still in progress.
        set_regs(16'd7, css_pkg::MODE_ADD);
        push_start(16'd3);
        push_advances(2);
        run_phase();
        set_regs(16'd10, css_pkg::MODE_MUL);
        push_advances(3);
        run_phase();

        set_regs(16'hFFFF, css_pkg::MODE_ADD);
        push_start(16'hFFFF);
        push_advances(1);
        run_phase();

        while (tracker.items < TARGET_ITEMS) begin
            random_phase();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        tracker.close_out();
        $display("Sent %0d items over %0d register settings: %0d starts, %0d non-units.",
                 tracker.items, settings_used, tracker.starts, tracker.non_units);
        $display("Completed %0d subgroup walks and %0d idle advances; %0d results checked.",
                 tracker.full_walks, tracker.idle_advances, tracker.checked);
        if (tracker.failures == 0) begin
            $display("** cyclic_subgroup_stepper_core: PASSED **");
        end else begin
            $display("** cyclic_subgroup_stepper_core: FAILED **");
        end
        $finish;
    end

endmodule
